// File: src/wlo_pkg.sv
// shared constants, operator codes and stage-to-stage types of the 3x3 window operator
package wlo_pkg;

  // field widths
  localparam int SampleW = 12;
  localparam int ValueW  = 32;
  localparam int NumTaps = 9;

  // square root unit: radicand and root widths
  localparam int RadW  = 52;
  localparam int RootW = RadW / 2;

  // operator codes, in register order
  typedef enum logic [4:0] {
    OP_AVERAGE    = 5'd0,
    OP_VARIANCE   = 5'd1,
    OP_DEVIATION  = 5'd2,
    OP_F          = 5'd3,
    OP_FX         = 5'd4,
    OP_FY         = 5'd5,
    OP_FXX        = 5'd6,
    OP_FXY        = 5'd7,
    OP_FYY        = 5'd8,
    OP_FXXY       = 5'd9,
    OP_FXYY       = 5'd10,
    OP_FXXYY      = 5'd11,
    OP_GRADIENT   = 5'd12,
    OP_LAPLACIAN  = 5'd13,
    OP_ORTHICITY  = 5'd14,
    OP_ELONGATION = 5'd15,
    OP_LINF       = 5'd16,
    OP_LINFX      = 5'd17,
    OP_LINFY      = 5'd18,
    OP_LINVAR     = 5'd19,
    OP_LINDEV     = 5'd20
  } op_e;

  // live configuration seen by the datapath
  typedef struct packed {
    op_e  op;
    logic smooth;
    logic square;
  } cfg_t;

  // request into the square root pipeline
  typedef struct packed {
    logic              need_sqrt;
    logic [RadW-1:0]   rad;
    logic [ValueW-1:0] res;
  } sqrt_req_t;

endpackage

// File: src/wlo_datapath.sv
// five-stage front end: window sums, products, variances and result or radicand select
module wlo_datapath (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        in_valid_i,
  input  logic [wlo_pkg::NumTaps-1:0][wlo_pkg::SampleW-1:0] samples_i,
  input  wlo_pkg::cfg_t                               cfg_i,
  output logic                                        out_valid_o,
  output wlo_pkg::sqrt_req_t                          req_o
);
  import wlo_pkg::*;

  typedef enum logic [2:0] {
    KIND_ZERO = 3'd0,
    KIND_LIN  = 3'd1,
    KIND_VAR  = 3'd2,
    KIND_DEV  = 3'd3,
    KIND_QRT  = 3'd4
  } kind_e;

  localparam int LinW   = 18;
  localparam int SlopeW = 15;
  localparam int SqrW   = 2 * SampleW;
  localparam int SsqW   = 28;
  localparam int QW     = 31;
  localparam int Stages = 5;

  // window taps, signed for differences
  logic signed [LinW-1:0] nw, n, ne, w, c, e, sw, s, se;
  assign nw = LinW'(samples_i[0]);
  assign n  = LinW'(samples_i[1]);
  assign ne = LinW'(samples_i[2]);
  assign w  = LinW'(samples_i[3]);
  assign c  = LinW'(samples_i[4]);
  assign e  = LinW'(samples_i[5]);
  assign sw = LinW'(samples_i[6]);
  assign s  = LinW'(samples_i[7]);
  assign se = LinW'(samples_i[8]);

  // linear combinations of the window
  logic signed [LinW-1:0] sa, dx, dy, ew, sn, t6s, t6, xy, t8s, t8;
  logic signed [LinW-1:0] t9, t10, t11, lap_s, lap, orth, orth2;
  assign sa    = (c <<< 2) + ((n + s + e + w) <<< 1) + nw + ne + sw + se;
  assign dx    = (ne + (e <<< 1) + se) - (nw + (w <<< 1) + sw);
  assign dy    = (sw + (s <<< 1) + se) - (nw + (n <<< 1) + ne);
  assign ew    = e - w;
  assign sn    = s - n;
  assign t6s   = (nw + (w <<< 1) + sw) - ((n + (c <<< 1) + s) <<< 1) + (ne + (e <<< 1) + se);
  assign t6    = e + w - (c <<< 1);
  assign xy    = se - sw - ne + nw;
  assign t8s   = (nw + (n <<< 1) + ne) - ((w + (c <<< 1) + e) <<< 1) + (sw + (s <<< 1) + se);
  assign t8    = s + n - (c <<< 1);
  assign t9    = (sw - (s <<< 1) + se) - (nw - (n <<< 1) + ne);
  assign t10   = (ne - (e <<< 1) + se) - (nw - (w <<< 1) + sw);
  assign t11   = (sw - (s <<< 1) + se) - ((w - (c <<< 1) + e) <<< 1) + (nw - (n <<< 1) + ne);
  assign lap_s = nw + ne + sw + se - (c <<< 2);
  assign lap   = e + w + s + n - (c <<< 2);
  assign orth  = e + w - s - n;
  assign orth2 = orth <<< 1;

  // operator decode: numerator, shifts and result kind
  kind_e                    kind_d;
  logic signed [LinW-1:0]   lin_d;
  logic [3:0]               ls_d, rs_d;
  logic signed [SlopeW-1:0] a_d, b_d;
  logic                     lvar_d, qsm_d;

  always_comb begin
    kind_d = KIND_LIN;
    lin_d  = '0;
    ls_d   = 4'd12;
    rs_d   = 4'd0;
    a_d    = dx[SlopeW-1:0];
    b_d    = dy[SlopeW-1:0];
    lvar_d = 1'b0;
    qsm_d  = 1'b0;
    case (cfg_i.op) inside
      OP_AVERAGE, OP_LINF: begin
        lin_d = sa; ls_d = 4'd8; rs_d = 4'd8;
      end
      OP_VARIANCE:  kind_d = KIND_VAR;
      OP_DEVIATION: kind_d = KIND_DEV;
      OP_F:         lin_d = c;
      OP_FX: begin
        if (cfg_i.smooth) begin
          lin_d = dx; ls_d = 4'd9; rs_d = 4'd6;
        end else begin
          lin_d = ew; ls_d = 4'd11; rs_d = 4'd2;
        end
      end
      OP_FY: begin
        if (cfg_i.smooth) begin
          lin_d = dy; ls_d = 4'd9; rs_d = 4'd6;
        end else begin
          lin_d = sn; ls_d = 4'd11; rs_d = 4'd2;
        end
      end
      OP_FXX: begin
        if (cfg_i.smooth) begin
          lin_d = t6s; ls_d = 4'd10; rs_d = 4'd4;
        end else begin
          lin_d = t6;
        end
      end
      OP_FXY: begin
        lin_d = xy; ls_d = 4'd10; rs_d = 4'd4;
      end
      OP_FYY: begin
        if (cfg_i.smooth) begin
          lin_d = t8s; ls_d = 4'd10; rs_d = 4'd4;
        end else begin
          lin_d = t8;
        end
      end
      OP_FXXY: begin
        lin_d = t9; ls_d = 4'd11; rs_d = 4'd2;
      end
      OP_FXYY: begin
        lin_d = t10; ls_d = 4'd11; rs_d = 4'd2;
      end
      OP_FXXYY: lin_d = t11;
      OP_GRADIENT: begin
        kind_d = KIND_QRT;
        qsm_d  = cfg_i.smooth;
        if (!cfg_i.smooth) begin
          a_d = ew[SlopeW-1:0];
          b_d = sn[SlopeW-1:0];
        end
      end
      OP_LAPLACIAN: begin
        if (cfg_i.smooth) begin
          lin_d = lap_s; ls_d = 4'd11; rs_d = 4'd2;
        end else begin
          lin_d = lap;
        end
      end
      OP_ORTHICITY: lin_d = orth;
      OP_ELONGATION: begin
        kind_d = KIND_QRT;
        a_d    = orth2[SlopeW-1:0];
        b_d    = xy[SlopeW-1:0];
      end
      OP_LINFX: begin
        lin_d = dx; ls_d = 4'd9; rs_d = 4'd6;
      end
      OP_LINFY: begin
        lin_d = dy; ls_d = 4'd9; rs_d = 4'd6;
      end
      OP_LINVAR: begin
        kind_d = KIND_VAR; lvar_d = 1'b1;
      end
      OP_LINDEV: begin
        kind_d = KIND_DEV; lvar_d = 1'b1;
      end
      default: kind_d = KIND_ZERO;
    endcase
  end

  // squares of the nine taps
  logic [SqrW-1:0] sqr_d [NumTaps];
  always_comb begin
    for (int i = 0; i < NumTaps; i++) begin
      sqr_d[i] = SqrW'(samples_i[i]) * SqrW'(samples_i[i]);
    end
  end

  // valid bits travel with the stages
  logic [Stages-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  // stage 1: decoded operator and tap squares
  kind_e                    kind1_q;
  logic signed [LinW-1:0]   lin1_q;
  logic [3:0]               ls1_q, rs1_q;
  logic signed [SlopeW-1:0] a1_q, b1_q;
  logic [LinW-2:0]          sa1_q;
  logic                     lvar1_q, qsm1_q;
  logic [SqrW-1:0]          sqr1_q [NumTaps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind1_q <= kind_d;
      lin1_q  <= lin_d;
      ls1_q   <= ls_d;
      rs1_q   <= rs_d;
      a1_q    <= a_d;
      b1_q    <= b_d;
      sa1_q   <= sa[LinW-2:0];
      lvar1_q <= lvar_d;
      qsm1_q  <= qsm_d;
      sqr1_q  <= sqr_d;
    end
  end

  // stage 2: products and weighted sum of squares
  kind_e                      kind2_q;
  logic signed [LinW-1:0]     lin2_q;
  logic [3:0]                 ls2_q, rs2_q;
  logic signed [2*LinW-1:0]   ll2_q;
  logic signed [2*SlopeW-1:0] aa2_q, bb2_q;
  logic [ValueW-1:0]          saa2_q;
  logic [SsqW-1:0]            ssq2_q;
  logic                       lvar2_q, qsm2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind2_q <= kind1_q;
      lin2_q  <= lin1_q;
      ls2_q   <= ls1_q;
      rs2_q   <= rs1_q;
      ll2_q   <= lin1_q * lin1_q;
      aa2_q   <= a1_q * a1_q;
      bb2_q   <= b1_q * b1_q;
      saa2_q  <= ValueW'(sa1_q) * ValueW'(sa1_q);
      ssq2_q  <= (SsqW'(sqr1_q[4]) << 2)
               + ((SsqW'(sqr1_q[1]) + SsqW'(sqr1_q[3]) + SsqW'(sqr1_q[5])
                 + SsqW'(sqr1_q[7])) << 1)
               + SsqW'(sqr1_q[0]) + SsqW'(sqr1_q[2]) + SsqW'(sqr1_q[6])
               + SsqW'(sqr1_q[8]);
      lvar2_q <= lvar1_q;
      qsm2_q  <= qsm1_q;
    end
  end

  // stage 3: variance, residual variance and linear results
  logic [ValueW-1:0]        var3, lvar3, lin_res3;
  logic [QW-1:0]            q3;
  logic [2*LinW-1:0]        ll_u;
  logic signed [ValueW-1:0] lin_ext;

  assign var3    = {ssq2_q, 4'b0000} - saa2_q;
  assign q3      = QW'($unsigned(aa2_q)) + QW'($unsigned(bb2_q));
  assign lvar3   = var3 - {q3, 1'b0};
  assign ll_u    = ll2_q;
  assign lin_ext = ValueW'(lin2_q);
  assign lin_res3 = cfg_i.square ? ValueW'(ll_u >> rs2_q) : ValueW'(lin_ext <<< ls2_q);

  kind_e             kind3_q;
  logic [ValueW-1:0] v3_q, lin3_q;
  logic [QW-1:0]     q3_q;
  logic              qsm3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind3_q <= kind2_q;
      v3_q    <= lvar2_q ? lvar3 : var3;
      lin3_q  <= lin_res3;
      q3_q    <= q3;
      qsm3_q  <= qsm2_q;
    end
  end

  // stage 4: square of the variance
  kind_e               kind4_q;
  logic [ValueW-1:0]   v4_q, lin4_q;
  logic [2*ValueW-1:0] vv4_q;
  logic [QW-1:0]       q4_q;
  logic                qsm4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind4_q <= kind3_q;
      v4_q    <= v3_q;
      vv4_q   <= (2*ValueW)'(v3_q) * (2*ValueW)'(v3_q);
      lin4_q  <= lin3_q;
      q4_q    <= q3_q;
      qsm4_q  <= qsm3_q;
    end
  end

  // stage 5: direct result or square root radicand
  sqrt_req_t req_d, req_q;
  always_comb begin
    req_d.need_sqrt = 1'b0;
    req_d.rad       = '0;
    req_d.res       = '0;
    case (kind4_q)
      KIND_LIN: req_d.res = lin4_q;
      KIND_VAR: begin
        req_d.res = cfg_i.square ? ValueW'(vv4_q >> 40) : (v4_q >> 8);
      end
      KIND_DEV: begin
        if (cfg_i.square) begin
          req_d.res = v4_q >> 8;
        end else begin
          req_d.need_sqrt = 1'b1;
          req_d.rad       = RadW'(v4_q) << 16;
        end
      end
      KIND_QRT: begin
        if (cfg_i.square) begin
          req_d.res = ValueW'(q4_q >> (qsm4_q ? 6 : 2));
        end else begin
          req_d.need_sqrt = 1'b1;
          req_d.rad       = RadW'(q4_q) << (qsm4_q ? 18 : 22);
        end
      end
      default: req_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q <= req_d;
    end
  end

  assign req_o       = req_q;
  assign out_valid_o = vld_q[Stages-1];

endmodule

// File: src/wlo_sqrt.sv
// pipelined floor square root, one root bit per stage, with a bypass result alongside
module wlo_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        in_valid_i,
  input  wlo_pkg::sqrt_req_t          req_i,
  output logic                        out_valid_o,
  output logic [wlo_pkg::ValueW-1:0]  out_value_o
);
  import wlo_pkg::*;

  logic              vld_q  [RootW];
  logic              need_q [RootW];
  logic [RadW-1:0]   rem_q  [RootW];
  logic [RootW-1:0]  root_q [RootW];
  logic [ValueW-1:0] res_q  [RootW];

  for (genvar i = 0; i < RootW; i++) begin : g_step
    localparam int Bit = RootW - 1 - i;

    logic              vld_in, need_in, fits;
    logic [RadW-1:0]   rem_in;
    logic [RootW-1:0]  root_in;
    logic [ValueW-1:0] res_in;
    logic [RadW:0]     trial;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign need_in = req_i.need_sqrt;
      assign rem_in  = req_i.rad;
      assign root_in = '0;
      assign res_in  = req_i.res;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign need_in = need_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign res_in  = res_q[i-1];
    end

    // (root + 2^bit)^2 - root^2 against the remainder
    assign trial = ((RadW + 1)'(root_in) << (Bit + 1)) + ((RadW + 1)'(1) << (2 * Bit));
    assign fits  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= fits ? (rem_in - trial[RadW-1:0]) : rem_in;
        root_q[i] <= fits ? (root_in | (RootW'(1) << Bit)) : root_in;
        need_q[i] <= need_in;
        res_q[i]  <= res_in;
      end
    end
  end

  // output register: root or bypassed result
  logic              out_vld_q;
  logic [ValueW-1:0] out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[RootW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_value_q <= need_q[RootW-1] ? ValueW'(root_q[RootW-1]) : res_q[RootW-1];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_value_o = out_value_q;

endmodule

// File: src/window_3x3_local_operator_unit.sv
// top level of the 3x3 window operator: register port, pipeline control and output
//
//   port group     kind          transfer when
//   ------------   -----------   ------------------------------------------
//   sample_*_i     input items   in_valid_i and in_ready_o high at clk edge
//   operator_*_o   results       out_valid_o and out_ready_i high at clk edge
//   p*             registers     psel, penable and pready high (pwrite for writes)
//
// one window per cycle unless the output stalls; five front-end stages, 26 square
// root stages (one root bit each) and the output register
// all stages advance together; when the output holds an untaken result the
// whole pipeline stalls and in_ready_o drops
// reset clears the valid bits and the registers (average, plain, not squared)
module window_3x3_local_operator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [wlo_pkg::SampleW-1:0]         sample_nw_i,
  input  logic [wlo_pkg::SampleW-1:0]         sample_n_i,
  input  logic [wlo_pkg::SampleW-1:0]         sample_ne_i,
  input  logic [wlo_pkg::SampleW-1:0]         sample_w_i,
  input  logic [wlo_pkg::SampleW-1:0]         sample_center_i,
  input  logic [wlo_pkg::SampleW-1:0]         sample_e_i,
  input  logic [wlo_pkg::SampleW-1:0]         sample_sw_i,
  input  logic [wlo_pkg::SampleW-1:0]         sample_s_i,
  input  logic [wlo_pkg::SampleW-1:0]         sample_se_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [wlo_pkg::ValueW-1:0]   operator_value_o
);
  import wlo_pkg::*;

  typedef enum logic [1:0] {
    REG_OPSEL  = 2'd0,
    REG_SMOOTH = 2'd1,
    REG_SQUARE = 2'd2
  } reg_e;

  // register file
  op_e  op_q;
  logic smooth_q, square_q;
  logic wr_en;
  reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_AVERAGE;
      smooth_q <= 1'b0;
      square_q <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OPSEL:  op_q     <= op_e'(pwdata[4:0]);
        REG_SMOOTH: smooth_q <= pwdata[0];
        REG_SQUARE: square_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_OPSEL:  prdata = 32'(op_q);
      REG_SMOOTH: prdata = 32'(smooth_q);
      REG_SQUARE: prdata = 32'(square_q);
      default:    prdata = '0;
    endcase
  end

  // pipeline advance
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  cfg_t cfg;
  assign cfg.op     = op_q;
  assign cfg.smooth = smooth_q;
  assign cfg.square = square_q;

  logic [NumTaps-1:0][SampleW-1:0] samples;
  assign samples = {sample_se_i, sample_s_i, sample_sw_i,
                    sample_e_i, sample_center_i, sample_w_i,
                    sample_ne_i, sample_n_i, sample_nw_i};

  // front end
  logic      front_valid;
  sqrt_req_t req;

  wlo_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .samples_i   (samples),
    .cfg_i       (cfg),
    .out_valid_o (front_valid),
    .req_o       (req)
  );

  // square root pipeline and output register
  logic [ValueW-1:0] value;

  wlo_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (front_valid),
    .req_i       (req),
    .out_valid_o (out_valid_o),
    .out_value_o (value)
  );

  assign operator_value_o = value;

  // checks
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a waiting result");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(operator_value_o)))
    else $error("waiting result changed");

  a_opsel_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && reg_idx == REG_OPSEL) |=> (op_q == op_e'($past(pwdata[4:0]))))
    else $error("operator register not written");

endmodule
